// File: hdl/command_byte_stream_parser_defines.svh
// assertion macros for the command byte stream parser checker
// needs clk and rst_n in the scope where a macro is used
`ifndef COMMAND_BYTE_STREAM_PARSER_DEFINES_SVH
`define COMMAND_BYTE_STREAM_PARSER_DEFINES_SVH

// antecedent holds, consequent must hold on the same edge
`define CBSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbsp check failed");

// antecedent holds, consequent must hold on the next edge
`define CBSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbsp check failed");

`endif

// File: hdl/cbsp_pkg.sv
// shared constants and types for the command byte stream parser
// no dependencies
package cbsp_pkg;

    localparam int LINE_MAX   = 32;
    localparam int LINE_CNT_W = $clog2(LINE_MAX + 1);

    // text parser phases
    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_ACT   = 3'd1;
    localparam logic [2:0] PH_SEP   = 3'd2;
    localparam logic [2:0] PH_COMMA = 3'd3;
    localparam logic [2:0] PH_VAL   = 3'd4;
    localparam logic [2:0] PH_TRAIL = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] DIGIT_MAX = 2'd3;

    // result of the text path for one byte
    typedef struct packed {
        logic       vld;
        logic [7:0] action;
        logic [7:0] value;
    } text_res_t;

endpackage

// File: hdl/cbsp_line_parser.sv
// incremental text line parser: holds the line state and parses one byte a step
// depends on cbsp_pkg
module cbsp_line_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output cbsp_pkg::text_res_t text_res
);
    import cbsp_pkg::*;

    logic [LINE_CNT_W-1:0] line_count_reg, line_count_next;
    logic [2:0]            phase_reg, phase_next;
    logic [7:0]            action_acc_reg, action_acc_next;
    logic [7:0]            value_acc_reg, value_acc_next;
    logic [1:0]            digit_count_reg, digit_count_next;

    logic       is_eol, is_text, is_dig, is_sp, is_comma;
    logic [3:0] dig_val;
    logic [7:0] acc_sel;
    logic [11:0] acc_sum;
    logic       start_num, add_fail;

    assign is_eol   = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign is_text  = (rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE);
    assign is_dig   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_sp    = (rx_byte == CH_SPACE);
    assign is_comma = (rx_byte == CH_COMMA);
    assign dig_val  = rx_byte[3:0];

    // action accumulates before the separator, value after it
    assign start_num = (phase_reg == PH_LEAD) || (phase_reg == PH_SEP) ||
                       (phase_reg == PH_COMMA);
    assign acc_sel   = ((phase_reg == PH_LEAD) || (phase_reg == PH_ACT)) ?
                       action_acc_reg : value_acc_reg;
    assign acc_sum   = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                       + {8'h00, dig_val};
    assign add_fail  = (acc_sum > 12'd255) ||
                       (!start_num && (digit_count_reg >= DIGIT_MAX));

    assign text_res.vld = step && is_eol && (line_count_reg != '0) &&
                          ((phase_reg == PH_ACT) || (phase_reg == PH_SEP) ||
                           (phase_reg == PH_VAL) || (phase_reg == PH_TRAIL));
    assign text_res.action = action_acc_reg;
    assign text_res.value  = value_acc_reg;

    always_comb
    begin
        line_count_next  = line_count_reg;
        phase_next       = phase_reg;
        action_acc_next  = action_acc_reg;
        value_acc_next   = value_acc_reg;
        digit_count_next = digit_count_reg;
        if (step)
        begin
            if (!is_text || (line_count_reg >= LINE_CNT_W'(LINE_MAX)))
            begin
                // line end, binary byte or overflow: restart the line
                line_count_next  = '0;
                phase_next       = PH_LEAD;
                action_acc_next  = '0;
                value_acc_next   = '0;
                digit_count_next = '0;
            end
            else
            begin
                line_count_next = line_count_reg + 1'b1;
                if (start_num && is_dig)
                    digit_count_next = add_fail ? 2'd0 : 2'd1;
                else if (is_dig && !add_fail)
                    digit_count_next = digit_count_reg + 1'b1;
                case (phase_reg)
                    PH_LEAD:
                    begin
                        if (is_dig)
                        begin
                            phase_next = add_fail ? PH_ERR : PH_ACT;
                            if (!add_fail)
                                action_acc_next = acc_sum[7:0];
                        end
                        else if (!is_sp)
                            phase_next = PH_ERR;
                    end
                    PH_ACT:
                    begin
                        if (is_dig)
                        begin
                            if (add_fail)
                                phase_next = PH_ERR;
                            else
                                action_acc_next = acc_sum[7:0];
                        end
                        else if (is_sp)
                            phase_next = PH_SEP;
                        else if (is_comma)
                            phase_next = PH_COMMA;
                        else
                            phase_next = PH_ERR;
                    end
                    PH_SEP, PH_COMMA:
                    begin
                        if (is_dig)
                        begin
                            phase_next = add_fail ? PH_ERR : PH_VAL;
                            if (!add_fail)
                                value_acc_next = acc_sum[7:0];
                        end
                        else if (is_comma && (phase_reg == PH_SEP))
                            phase_next = PH_COMMA;
                        else if (!is_sp)
                            phase_next = PH_ERR;
                    end
                    PH_VAL:
                    begin
                        if (is_dig)
                        begin
                            if (add_fail)
                                phase_next = PH_ERR;
                            else
                                value_acc_next = acc_sum[7:0];
                        end
                        else if (is_sp)
                            phase_next = PH_TRAIL;
                        else
                            phase_next = PH_ERR;
                    end
                    PH_TRAIL:
                    begin
                        if (!is_sp)
                            phase_next = PH_ERR;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg  <= '0;
            phase_reg       <= PH_LEAD;
            action_acc_reg  <= '0;
            value_acc_reg   <= '0;
            digit_count_reg <= '0;
        end
        else
        begin
            line_count_reg  <= line_count_next;
            phase_reg       <= phase_next;
            action_acc_reg  <= action_acc_next;
            value_acc_reg   <= value_acc_next;
            digit_count_reg <= digit_count_next;
        end
    end

endmodule

// File: hdl/command_byte_stream_parser.sv
// channel | handshake            | payload                            | transaction
// input   | in_valid, in_stall   | rx_byte                            | one received byte
// output  | out_valid, out_stall | cmd_action, cmd_value, from_binary | one parsed command
//
// one byte per cycle sustained while out_stall is low; a byte's command lands in the result register
// when the byte makes one pass from the input register through the line parser and pair logic
// rst_n is asynchronous, active low; it clears the line, the half pair and both valids
// out_stall holds the result register; the input register then holds its byte and
// in_stall rises only while a byte waits behind a stalled result
// depends on cbsp_pkg and cbsp_line_parser
module command_byte_stream_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] cmd_action,
    output logic [7:0] cmd_value,
    output logic       from_binary
);
    import cbsp_pkg::*;

    // input register
    logic       item_vld_reg;
    logic [7:0] byte_reg;

    // binary pair state; the first byte is only read while a pair is pending
    logic       pair_pending_reg, pair_pending_next;
    logic [7:0] pair_first_reg;

    // result register
    logic       out_vld_reg;
    logic [7:0] action_reg, value_reg;
    logic       binary_reg;

    logic       advance, in_take, step;
    logic       is_eol, is_text, is_binary, pair_done;
    text_res_t  text_res;

    // the pass runs whenever the result register is free or being emptied
    assign advance = !out_vld_reg || !out_stall;
    assign in_stall = item_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign step     = item_vld_reg && advance;

    assign is_eol    = (byte_reg == CH_CR) || (byte_reg == CH_LF);
    assign is_text   = (byte_reg >= CH_SPACE) && (byte_reg <= CH_TILDE);
    assign is_binary = !is_eol && !is_text;
    assign pair_done = step && is_binary && pair_pending_reg;

    cbsp_line_parser u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .rx_byte  (byte_reg),
        .text_res (text_res)
    );

    // a binary byte either opens a pair or closes it; anything else drops a half pair
    always_comb
    begin
        pair_pending_next = pair_pending_reg;
        if (step)
            pair_pending_next = is_binary && !pair_pending_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg     <= 1'b0;
            pair_pending_reg <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            if (in_take)
                item_vld_reg <= 1'b1;
            else if (advance)
                item_vld_reg <= 1'b0;
            pair_pending_reg <= pair_pending_next;
            if (pair_done || text_res.vld)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            byte_reg <= rx_byte;
        if (step && is_binary && !pair_pending_reg)
            pair_first_reg <= byte_reg;
        if (pair_done)
        begin
            action_reg <= pair_first_reg;
            value_reg  <= byte_reg;
            binary_reg <= 1'b1;
        end
        else if (text_res.vld)
        begin
            action_reg <= text_res.action;
            value_reg  <= text_res.value;
            binary_reg <= 1'b0;
        end
    end

    assign out_valid   = out_vld_reg;
    assign cmd_action  = action_reg;
    assign cmd_value   = value_reg;
    assign from_binary = binary_reg;

endmodule

// File: hdl/cbsp_port_checker.sv
// port-level checks for the command byte stream parser, bound to the top level
// depends on command_byte_stream_parser_defines.svh
`include "command_byte_stream_parser_defines.svh"

module cbsp_port_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] cmd_action,
    input logic [7:0] cmd_value,
    input logic       from_binary
);

    // a stalled result stays put
    `CBSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(cmd_action) && $stable(cmd_value) && $stable(from_binary))

    // a fresh result comes from an earlier accepted byte that passed through the input register
    `CBSP_ASSERT_NOW(a_rise_src, $rose(out_valid), $past(in_valid && !in_stall, 2))

    // a fresh text result is caused by a line end
    `CBSP_ASSERT_NOW(a_text_eol, $rose(out_valid) && !from_binary,
        $past(rx_byte == 8'h0D, 2) || $past(rx_byte == 8'h0A, 2))

    // a fresh binary result carries the closing byte as its value
    `CBSP_ASSERT_NOW(a_pair_val, $rose(out_valid) && from_binary,
        cmd_value == $past(rx_byte, 2))

endmodule

bind command_byte_stream_parser cbsp_port_checker u_cbsp_port_checker (.*);

// File: bench/testbench.sv
// self-checking bench for command_byte_stream_parser: table-driven directed bytes, then random
// text lines, binary pairs and noise, checked against an in-bench line and pair parser
// depends on cbsp_pkg and the parser rtl
module testbench;
    import cbsp_pkg::*;

    localparam int ITEMS          = 1250;
    localparam int CALM_ITEMS     = 150;   // last stretch of the run with no idling
    localparam int HOLD_AT        = 400;
    localparam int DRAIN_AT       = 800;
    localparam int HOLD_CYCLES    = 120;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // one parsed command as seen on the result channel
    typedef struct packed {
        logic [7:0] action;
        logic [7:0] value;
        logic       binary;
    } cmd_t;

    // how a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT,    // whatever the bench parser says
        ROW_CMD,        // the command typed into the row
        ROW_NONE        // no command at all
    } row_kind_t;

    typedef struct packed {
        logic [7:0] rx;
        row_kind_t  kind;
        logic [7:0] action;
        logic [7:0] value;
        logic       binary;
    } row_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] cmd_action;
    logic [7:0] cmd_value;
    logic       from_binary;

    command_byte_stream_parser u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cmd_action  (cmd_action),
        .cmd_value   (cmd_value),
        .from_binary (from_binary)
    );

    // directed bytes; only the line ends, the binary bytes and the tilde carry a typed expectation
    row_t dir_rows [24] = '{
        // leading space, space before the comma, trailing space, both numbers at 255
        '{CH_SPACE, ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"2",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"5",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"5",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_SPACE, ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_COMMA, ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"2",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"5",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"5",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_SPACE, ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_LF,    ROW_CMD,     8'd255, 8'd255, 1'b0},
        // value left out reads as zero, line closed by cr
        '{"7",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_CR,    ROW_CMD,     8'd7, 8'd0, 1'b0},
        // number above 255 spoils the line
        '{"2",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"5",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{"6",      ROW_PREDICT, 8'd0, 8'd0, 1'b0},
        '{CH_CR,    ROW_NONE,    8'd0, 8'd0, 1'b0},
        // empty line
        '{CH_LF,    ROW_NONE,    8'd0, 8'd0, 1'b0},
        // binary pair at both byte extremes
        '{8'h00,    ROW_NONE,    8'd0, 8'd0, 1'b0},
        '{8'hFF,    ROW_CMD,     8'd0, 8'd255, 1'b1},
        // tab is a binary byte; the tilde drops it, then a fresh pair
        '{8'h09,    ROW_NONE,    8'd0, 8'd0, 1'b0},
        '{CH_TILDE, ROW_NONE,    8'd0, 8'd0, 1'b0},
        '{8'h7F,    ROW_NONE,    8'd0, 8'd0, 1'b0},
        '{8'h80,    ROW_CMD,     8'd127, 8'd128, 1'b1}
    };

    // bench copy of the parser state
    int          line_len;
    logic [2:0]  phase;
    logic [7:0]  act_acc;
    logic [7:0]  val_acc;
    logic [1:0]  digit_cnt;
    logic        half_held;
    logic [7:0]  half_byte;

    cmd_t        expected_cmds [$];   // commands still owed by the block, oldest first
    row_t        row_notes [$];       // typed expectations of directed rows in flight
    logic [7:0]  line_buf [$];        // text line being put together by the stimulus

    int          mismatches = 0;
    int          items_sent = 0;
    int          quiet_cycles = 0;
    int          hold_req = 0;        // bumped to ask the receiver for one long hold-off
    bit          calm = 1'b0;         // no idling on either side once set

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- bench parser

    task automatic clear_line();
        line_len  = 0;
        phase     = PH_LEAD;
        act_acc   = '0;
        val_acc   = '0;
        digit_cnt = '0;
    endtask

    // append one digit to the action or the value; a fourth digit or a sum above 255
    // puts the line in error
    task automatic take_digit(input bit into_value, input logic [7:0] b);
        int sum;
        sum = int'(into_value ? val_acc : act_acc) * 10 + int'(b - CH_ZERO);
        if (sum > 255 || digit_cnt >= DIGIT_MAX)
            phase = PH_ERR;
        else
        begin
            if (into_value)
                val_acc = sum[7:0];
            else
                act_acc = sum[7:0];
            digit_cnt = digit_cnt + 2'd1;
            phase = into_value ? PH_VAL : PH_ACT;
        end
    endtask

    task automatic parse_text_byte(input logic [7:0] b);
        bit digit;
        bit space;
        digit = (b >= CH_ZERO && b <= CH_NINE);
        space = (b == CH_SPACE);
        case (phase)
            PH_LEAD:
                if (digit)
                begin
                    digit_cnt = '0;
                    take_digit(1'b0, b);
                end
                else if (!space)
                    phase = PH_ERR;
            PH_ACT:
                if (digit)
                    take_digit(1'b0, b);
                else if (space)
                    phase = PH_SEP;
                else if (b == CH_COMMA)
                    phase = PH_COMMA;
                else
                    phase = PH_ERR;
            // spaces after the action may still lead to a comma; after the comma only
            // spaces and the first digit of the value
            PH_SEP, PH_COMMA:
                if (!space)
                begin
                    if (phase == PH_SEP && b == CH_COMMA)
                        phase = PH_COMMA;
                    else if (digit)
                    begin
                        digit_cnt = '0;
                        take_digit(1'b1, b);
                    end
                    else
                        phase = PH_ERR;
                end
            PH_VAL:
                if (digit)
                    take_digit(1'b1, b);
                else if (space)
                    phase = PH_TRAIL;
                else
                    phase = PH_ERR;
            PH_TRAIL:
                if (!space)
                    phase = PH_ERR;
            default:
                ;
        endcase
    endtask

    // one accepted byte in, at most one command out
    task automatic parse_rx_byte(input logic [7:0] b, output bit made, output cmd_t c);
        made = 1'b0;
        c = '0;
        if (b == CH_CR || b == CH_LF)
        begin
            if (line_len > 0 && (phase == PH_ACT || phase == PH_SEP ||
                                 phase == PH_VAL || phase == PH_TRAIL))
            begin
                made = 1'b1;
                c = '{act_acc, val_acc, 1'b0};
            end
            clear_line();
            half_held = 1'b0;
        end
        else if (b >= CH_SPACE && b <= CH_TILDE)
        begin
            half_held = 1'b0;
            if (line_len < LINE_MAX)
            begin
                line_len++;
                parse_text_byte(b);
            end
            else
                clear_line();   // overflow drops the byte and restarts the line
        end
        else
        begin
            clear_line();
            if (half_held)
            begin
                made = 1'b1;
                c = '{half_byte, b, 1'b1};
                half_held = 1'b0;
            end
            else
            begin
                half_byte = b;
                half_held = 1'b1;
            end
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // both channels sampled at the edge, on values settled before it
    always @(posedge clk)
    begin : monitor
        bit   made;
        cmd_t next_cmd;
        cmd_t want;
        row_t note;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_cmds.size() == 0)
            begin
                mismatches++;
                $display("%0t: command with none expected, expected nothing, actual %0d %0d %0d",
                         $time, cmd_action, cmd_value, from_binary);
            end
            else
            begin
                want = expected_cmds.pop_front();
                check_field("cmd_action", want.action, cmd_action);
                check_field("cmd_value", want.value, cmd_value);
                check_field("from_binary", {7'd0, want.binary}, {7'd0, from_binary});
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            parse_rx_byte(rx_byte, made, next_cmd);
            // a directed row with a typed expectation stands in for the bench parser
            if (row_notes.size() != 0)
            begin
                note = row_notes.pop_front();
                if (note.kind == ROW_CMD)
                begin
                    made = 1'b1;
                    next_cmd = '{note.action, note.value, note.binary};
                end
                else if (note.kind == ROW_NONE)
                    made = 1'b0;
            end
            if (made)
                expected_cmds.push_back(next_cmd);
        end
    end

    // a long run of edges with no transaction on either channel means the block hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- receiver

    // random stall bursts, plus one long hold-off on request so the block backs up
    initial
    begin
        int hold_seen;
        hold_seen = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- sender

    // offer one byte and hold it until the transaction completes; called just after an edge
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    function automatic logic [7:0] rand_binary();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_SPACE && b <= CH_TILDE) || b == CH_CR || b == CH_LF);
        return b;
    endfunction

    // decimal digits of n, zero padded to a random width of at most three, or to four
    task automatic put_number(input int n, input bit four_digits);
        int w;
        int p;
        w = (n > 99) ? 3 : (n > 9) ? 2 : 1;
        w = four_digits ? 4 : $urandom_range(w, 3);
        for (int i = w - 1; i >= 0; i--)
        begin
            p = 1;
            repeat (i) p = p * 10;
            line_buf.push_back(CH_ZERO + 8'((n / p) % 10));
        end
    endtask

    // a text line in any of its legal shapes; a broken one gets a stray byte, a number
    // above 255, a fourth digit or a binary byte in the middle
    task automatic send_line(input bit broken);
        int fault;
        int act_n;
        line_buf.delete();
        fault = broken ? $urandom_range(0, 3) : 4;
        act_n = (fault == 1) ? $urandom_range(256, 999) : $urandom_range(0, 255);
        repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
        put_number(act_n, fault == 2);
        case ($urandom_range(0, 2))
            0:
                ;
            1:
            begin
                repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
                line_buf.push_back(CH_COMMA);
                repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
                put_number($urandom_range(0, 255), 1'b0);
            end
            default:
            begin
                repeat ($urandom_range(1, 3)) line_buf.push_back(CH_SPACE);
                put_number($urandom_range(0, 255), 1'b0);
            end
        endcase
        repeat ($urandom_range(0, 2)) line_buf.push_back(CH_SPACE);
        if (fault == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] =
                8'($urandom_range(CH_SPACE, CH_TILDE));
        else if (fault == 3)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = rand_binary();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        send_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endtask

    task automatic send_pair();
        send_byte(rand_binary());
        send_byte(rand_binary());
    endtask

    // filler right around the line length limit, then a line that may land past it
    task automatic send_long_line();
        int pick;
        repeat ($urandom_range(LINE_MAX - 3, LINE_MAX + 1))
        begin
            pick = $urandom_range(0, 3);
            send_byte(pick == 0 ? CH_COMMA : pick == 1 ? CH_ZERO + 8'($urandom_range(0, 9))
                                                       : CH_SPACE);
        end
        send_line(1'b0);
    endtask

    // half pair dropped by text, then a line cut short by a binary pair
    task automatic send_cut_mix();
        send_byte(rand_binary());
        send_line(1'b0);
        send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        send_pair();
        send_byte(CH_CR);
    endtask

    initial
    begin
        int pick;
        bit held;
        bit drained;
        held = 1'b0;
        drained = 1'b0;
        clear_line();
        half_held = 1'b0;
        half_byte = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row_notes.push_back(dir_rows[i]);
            send_byte(dir_rows[i].rx);
        end
        send_long_line();

        // mostly well-formed lines and pairs with random content, the rest noise
        while (items_sent < ITEMS)
        begin
            if (!held && items_sent >= HOLD_AT)
            begin
                // receiver holds off while pairs keep coming, so the input backs up
                held = 1'b1;
                hold_req <= hold_req + 1;
                repeat (12) send_pair();
            end
            if (!drained && items_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_cmds.size() != 0);
            end
            calm <= (items_sent >= ITEMS - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_line(1'b0);
            else if (pick < 65)
                send_pair();
            else if (pick < 75)
                send_line(1'b1);
            else if (pick < 85)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            else if (pick < 90)
                send_long_line();
            else
                send_cut_mix();
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_cmds.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/cbsp_pkg.sv
hdl/cbsp_line_parser.sv
hdl/command_byte_stream_parser.sv
hdl/cbsp_port_checker.sv
bench/testbench.sv
